// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the lock unit RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define RRWL_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Checks that a trigger is followed by the condition in the next cycle.
`define RRWL_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

// File: hw/rtl/rrwl_pkg.sv
// Types and codes shared by the recursive reader/writer lock unit.
package rrwl_pkg;

    // Request operation codes.
    localparam logic [1:0] OP_SHARED_LOCK   = 2'd0;
    localparam logic [1:0] OP_SHARED_UNLOCK = 2'd1;
    localparam logic [1:0] OP_EXCL_LOCK     = 2'd2;
    localparam logic [1:0] OP_EXCL_UNLOCK   = 2'd3;

    // Response status codes.
    localparam logic [1:0] ST_GRANTED  = 2'd0;
    localparam logic [1:0] ST_BUSY     = 2'd1;
    localparam logic [1:0] ST_NOT_HELD = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    // Lock mode codes.
    localparam logic [1:0] MODE_FREE   = 2'd0;
    localparam logic [1:0] MODE_SHARED = 2'd1;
    localparam logic [1:0] MODE_EXCL   = 2'd2;

    localparam int ID_BITS = 4;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [ID_BITS-1:0] requester_id;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [1:0]         lock_mode;
        logic [ID_BITS-1:0] owner_id;
    } rsp_t;

endpackage

// File: hw/rtl/rrwl_req_if.sv
// Valid/ready channel that carries lock requests.
interface rrwl_req_if;
    logic          valid;
    logic          ready;
    rrwl_pkg::req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: hw/rtl/rrwl_rsp_if.sv
// Valid/ready channel that carries lock responses.
interface rrwl_rsp_if;
    logic          valid;
    logic          ready;
    rrwl_pkg::rsp_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: hw/rtl/recursive_reader_writer_lock.sv
// Top level of the recursive reader/writer lock unit with upgrade.
// A request beat is taken into the request register and processed from there into the
// response register. Throughput: one request per cycle; a stalled response holds the
// request register, so the request side waits exactly as long as the response side.
// Reset clears the owner, depth, shared total, every shared counter and the valid
// flags of the request and response registers.
`include "assert_macros.svh"

module recursive_reader_writer_lock #(
    parameter int NUM_REQUESTERS = 16,
    parameter int COUNT_BITS     = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    rrwl_req_if.sink   req,
    rrwl_rsp_if.source rsp
);

    // Only identities that fit the request field can ever hold a counter.
    localparam int NUM_SLOTS  = (NUM_REQUESTERS < (1 << rrwl_pkg::ID_BITS)) ?
                                NUM_REQUESTERS : (1 << rrwl_pkg::ID_BITS);
    localparam int SLOT_BITS  = $clog2(NUM_SLOTS);
    localparam int TOTAL_BITS = COUNT_BITS + SLOT_BITS;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // Request register.
    logic           req_valid_reg;
    rrwl_pkg::req_t req_payload_reg;

    // Response register.
    logic           rsp_valid_reg;
    rrwl_pkg::rsp_t rsp_payload_reg;
    rrwl_pkg::rsp_t rsp_payload_next;

    // Lock state.
    logic                          owner_valid_reg;
    logic                          owner_valid_next;
    logic [rrwl_pkg::ID_BITS-1:0]  owner_reg;
    logic [rrwl_pkg::ID_BITS-1:0]  owner_next;
    logic [COUNT_BITS-1:0]         depth_reg;
    logic [COUNT_BITS-1:0]         depth_next;
    logic [TOTAL_BITS-1:0]         total_reg;
    logic [TOTAL_BITS-1:0]         total_next;
    logic [COUNT_BITS-1:0]         shared_cnt_reg [NUM_SLOTS];
    logic [COUNT_BITS-1:0]         shared_cnt_next;
    logic                          shared_cnt_we;

    // Decode of the registered request.
    logic                          advance;
    logic                          process;
    logic [1:0]                    op;
    logic [rrwl_pkg::ID_BITS-1:0]  id;
    logic                          in_range;
    logic [SLOT_BITS-1:0]          slot;
    logic [COUNT_BITS-1:0]         cnt;
    logic [1:0]                    status;

    // Handshake: the request register refills whenever its beat moves on.
    assign advance   = !rsp_valid_reg || rsp.ready;
    assign process   = req_valid_reg && advance;
    assign req.ready = !req_valid_reg || advance;
    assign rsp.valid = rsp_valid_reg;
    assign rsp.payload = rsp_payload_reg;

    assign op       = req_payload_reg.req_type;
    assign id       = req_payload_reg.requester_id;
    assign in_range = int'(id) < NUM_REQUESTERS;
    assign slot     = in_range ? SLOT_BITS'(id) : '0;
    assign cnt      = shared_cnt_reg[slot];

    // Lock operation on the registered request.
    always_comb
    begin
        owner_valid_next = owner_valid_reg;
        owner_next       = owner_reg;
        depth_next       = depth_reg;
        total_next       = total_reg;
        shared_cnt_next  = cnt;
        shared_cnt_we    = 1'b0;
        status           = rrwl_pkg::ST_GRANTED;

        if (!in_range)
        begin
            status = rrwl_pkg::ST_NOT_HELD;
        end
        else
        begin
            unique case (op)
                rrwl_pkg::OP_SHARED_LOCK:
                begin
                    if (owner_valid_reg && owner_reg != id)
                    begin
                        status = rrwl_pkg::ST_BUSY;
                    end
                    else if (cnt == COUNT_MAX)
                    begin
                        status = rrwl_pkg::ST_OVERFLOW;
                    end
                    else
                    begin
                        shared_cnt_next = cnt + 1'b1;
                        shared_cnt_we   = 1'b1;
                        total_next      = total_reg + 1'b1;
                    end
                end
                rrwl_pkg::OP_SHARED_UNLOCK:
                begin
                    if (cnt == '0)
                    begin
                        status = rrwl_pkg::ST_NOT_HELD;
                    end
                    else
                    begin
                        shared_cnt_next = cnt - 1'b1;
                        shared_cnt_we   = 1'b1;
                        total_next      = total_reg - 1'b1;
                    end
                end
                rrwl_pkg::OP_EXCL_LOCK:
                begin
                    if (owner_valid_reg)
                    begin
                        if (owner_reg != id)
                        begin
                            status = rrwl_pkg::ST_BUSY;
                        end
                        else if (depth_reg == COUNT_MAX)
                        begin
                            status = rrwl_pkg::ST_OVERFLOW;
                        end
                        else
                        begin
                            depth_next = depth_reg + 1'b1;
                        end
                    end
                    else if (total_reg > TOTAL_BITS'(cnt))
                    begin
                        status = rrwl_pkg::ST_BUSY;
                    end
                    else
                    begin
                        // Upgrade: fold the requester's shared counts away.
                        total_next       = total_reg - TOTAL_BITS'(cnt);
                        shared_cnt_next  = '0;
                        shared_cnt_we    = 1'b1;
                        owner_valid_next = 1'b1;
                        owner_next       = id;
                        depth_next       = COUNT_BITS'(1);
                    end
                end
                rrwl_pkg::OP_EXCL_UNLOCK:
                begin
                    if (!owner_valid_reg || owner_reg != id || depth_reg == '0)
                    begin
                        status = rrwl_pkg::ST_NOT_HELD;
                    end
                    else
                    begin
                        depth_next = depth_reg - 1'b1;
                        if (depth_reg == COUNT_BITS'(1))
                        begin
                            owner_valid_next = 1'b0;
                            owner_next       = '0;
                        end
                    end
                end
            endcase
        end
    end

    // Response fields reflect the state after the request.
    always_comb
    begin
        rsp_payload_next.status = status;
        if (owner_valid_next)
        begin
            rsp_payload_next.lock_mode = rrwl_pkg::MODE_EXCL;
        end
        else if (total_next != '0)
        begin
            rsp_payload_next.lock_mode = rrwl_pkg::MODE_SHARED;
        end
        else
        begin
            rsp_payload_next.lock_mode = rrwl_pkg::MODE_FREE;
        end
        rsp_payload_next.owner_id = owner_valid_next ? owner_next : '0;
    end

    // Request and response registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                req_valid_reg <= 1'b1;
            end
            else if (process)
            begin
                req_valid_reg <= 1'b0;
            end

            if (process)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            req_payload_reg <= req.payload;
        end
        if (process)
        begin
            rsp_payload_reg <= rsp_payload_next;
        end
    end

    // Lock state update, once per processed request.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owner_valid_reg <= 1'b0;
            owner_reg       <= '0;
            depth_reg       <= '0;
            total_reg       <= '0;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                shared_cnt_reg[i] <= '0;
            end
        end
        else if (process)
        begin
            owner_valid_reg <= owner_valid_next;
            owner_reg       <= owner_next;
            depth_reg       <= depth_next;
            total_reg       <= total_next;
            if (shared_cnt_we)
            begin
                shared_cnt_reg[slot] <= shared_cnt_next;
            end
        end
    end

    // An owner exists exactly when the nesting depth is nonzero.
    `RRWL_ASSERT_ALWAYS(a_owner_depth, owner_valid_reg == (depth_reg != '0), "owner and depth disagree")
    // With no owner the owner identity reads as zero.
    `RRWL_ASSERT_ALWAYS(a_owner_clear, owner_valid_reg || owner_reg == '0, "stale owner identity")
    // A granted exclusive lock leaves the requester as owner.
    `RRWL_ASSERT_NEXT(a_excl_grant, process && in_range && op == rrwl_pkg::OP_EXCL_LOCK && status == rrwl_pkg::ST_GRANTED, owner_valid_reg && owner_reg == $past(id), "exclusive grant lost")

endmodule
